FILE: rtl/cpr_pkg.sv
// Shared types and constants for the climate PID and relay controller.
package cpr_pkg;

  typedef enum logic [1:0] {
    ACT_OTHER = 2'd0,
    ACT_TEMP  = 2'd1,
    ACT_HUMI  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    CFG_TARGET_TEMP  = 3'd0,
    CFG_TARGET_HUMI  = 3'd1,
    CFG_GAIN_P       = 3'd2,
    CFG_GAIN_I       = 3'd3,
    CFG_GAIN_D       = 3'd4,
    CFG_MANUAL_MODES = 3'd5
  } cfg_index_e;

  localparam int MODE_HEAT = 0;
  localparam int MODE_HUMI = 1;
  localparam int MODE_FAN  = 2;

  localparam int ERR_FORCE_HI = 200;
  localparam int ERR_FORCE_LO = -30;
  localparam int INT_BAND     = 50;
  localparam int INT_LIMIT    = 10000;
  localparam int HUMI_HYST    = 150;
  localparam int FAN_MARGIN   = 100;

  localparam int LEVEL_W = 10;
  localparam logic [LEVEL_W-1:0] HEAT_FULL = 10'd1000;
  localparam logic [LEVEL_W-1:0] HEAT_OFF  = 10'd0;

  // Weighted PID sum before the divide by 1000.
  localparam int NUM_W      = 35;
  localparam int SAT_HI_NUM = 1000000;
  localparam int SAT_LO_NUM = 1000;

  // Quotient by 1000 of a value below 2**20, as a reciprocal multiply.
  localparam int DIV_W       = 20;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_K = 21'd1073742;

  typedef struct packed {
    logic               written;
    logic               scale;
    logic [LEVEL_W-1:0] level;
    logic [DIV_W-1:0]   num;
  } heat_req_t;

  typedef struct packed {
    logic humi_on;
    logic humi_chg;
    logic fan_on;
    logic fan_chg;
  } relay_t;

endpackage

FILE: rtl/cpr_pid.sv
// Heater PID step with anti-windup, holding the integral and previous error.
module cpr_pid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [1:0]        action_i,
  input  logic [15:0]       cur_temp_i,
  input  logic [15:0]       target_temp_i,
  input  logic [15:0]       gain_p_i,
  input  logic [15:0]       gain_i_i,
  input  logic [15:0]       gain_d_i,
  input  logic              manual_heat_i,
  output cpr_pkg::heat_req_t heat_o
);
  import cpr_pkg::*;

  logic signed [15:0]      integral_q, integral_d;
  logic signed [8:0]       prev_err_q, prev_err_d;
  logic signed [16:0]      err;
  logic signed [8:0]       err9;
  logic                    forced_hi, forced_lo, in_band;
  logic signed [16:0]      int_sum;
  logic signed [15:0]      int_acc, int_out;
  logic signed [9:0]       diff;
  logic signed [25:0]      pterm;
  logic signed [26:0]      dterm;
  logic signed [32:0]      iterm;
  logic signed [NUM_W-1:0] num;
  logic                    sat_hi, sat_lo, is_temp;

  assign err       = $signed({1'b0, target_temp_i}) - $signed({1'b0, cur_temp_i});
  assign err9      = err[8:0];
  assign forced_hi = err > ERR_FORCE_HI;
  assign forced_lo = err < ERR_FORCE_LO;
  assign in_band   = (err9 > -INT_BAND) && (err9 < INT_BAND);
  assign is_temp   = action_i == ACT_TEMP;

  assign int_sum = 17'(integral_q) + 17'(err9);

  always_comb begin
    if (!in_band) begin
      int_acc = '0;
    end else if (int_sum > INT_LIMIT) begin
      int_acc = 16'(INT_LIMIT);
    end else if (int_sum < -INT_LIMIT) begin
      int_acc = 16'(-INT_LIMIT);
    end else begin
      int_acc = int_sum[15:0];
    end
  end

  assign diff  = 10'(err9) - 10'(prev_err_q);
  assign pterm = 26'($signed({1'b0, gain_p_i})) * 26'(err9);
  assign dterm = 27'($signed({1'b0, gain_d_i})) * 27'(diff);
  assign iterm = 33'($signed({1'b0, gain_i_i})) * 33'(int_acc);
  assign num   = NUM_W'(pterm) + NUM_W'(iterm) + NUM_W'(dterm);

  assign sat_hi = num >= SAT_HI_NUM;
  assign sat_lo = num < SAT_LO_NUM;

  always_comb begin
    if ((sat_hi && err9 > 0) || (sat_lo && err9 < 0)) begin
      int_out = int_acc - 16'(err9);
    end else begin
      int_out = int_acc;
    end
  end

  always_comb begin
    integral_d = integral_q;
    prev_err_d = prev_err_q;
    heat_o     = '0;
    if (is_temp) begin
      heat_o.written = 1'b1;
      if (manual_heat_i) begin
        heat_o.level = HEAT_FULL;
      end else if (forced_hi || forced_lo) begin
        heat_o.level = forced_hi ? HEAT_FULL : HEAT_OFF;
        if (step_i) begin
          integral_d = '0;
        end
      end else begin
        if (sat_hi) begin
          heat_o.level = HEAT_FULL;
        end else if (sat_lo) begin
          heat_o.level = HEAT_OFF;
        end else begin
          heat_o.scale = 1'b1;
          heat_o.num   = num[DIV_W-1:0];
        end
        if (step_i) begin
          integral_d = int_out;
          prev_err_d = err9;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      prev_err_q <= '0;
    end else begin
      integral_q <= integral_d;
      prev_err_q <= prev_err_d;
    end
  end

endmodule

FILE: rtl/cpr_relay.sv
// Humidifier hysteresis relay and exhaust fan relay.
module cpr_relay (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [1:0]     action_i,
  input  logic [15:0]    cur_temp_i,
  input  logic [15:0]    cur_humi_i,
  input  logic [15:0]    target_temp_i,
  input  logic [15:0]    target_humi_i,
  input  logic           manual_humi_i,
  input  logic           manual_fan_i,
  output cpr_pkg::relay_t relay_o
);
  import cpr_pkg::*;

  logic humi_q, humi_d;
  logic fan_q, fan_d;
  logic humi_want_on, humi_want_off, fan_want;

  assign humi_want_on  = (target_humi_i >= 16'(HUMI_HYST)) &&
                         ({1'b0, cur_humi_i} < ({1'b0, target_humi_i} - 17'(HUMI_HYST)));
  assign humi_want_off = cur_humi_i >= target_humi_i;
  assign fan_want      = {1'b0, cur_temp_i} > ({1'b0, target_temp_i} + 17'(FAN_MARGIN));

  always_comb begin
    relay_o = '0;
    humi_d  = humi_q;
    fan_d   = fan_q;
    relay_o.humi_on = humi_q;
    relay_o.fan_on  = fan_q;
    if (action_i == ACT_HUMI && !manual_humi_i) begin
      if (humi_want_on) begin
        relay_o.humi_on  = 1'b1;
        relay_o.humi_chg = !humi_q;
      end else if (humi_want_off) begin
        relay_o.humi_on  = 1'b0;
        relay_o.humi_chg = humi_q;
      end
    end
    if (!manual_fan_i) begin
      relay_o.fan_on  = fan_want;
      relay_o.fan_chg = fan_want != fan_q;
    end
    if (step_i) begin
      humi_d = relay_o.humi_on;
      fan_d  = relay_o.fan_on;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      humi_q <= 1'b0;
      fan_q  <= 1'b0;
    end else begin
      humi_q <= humi_d;
      fan_q  <= fan_d;
    end
  end

endmodule

FILE: rtl/cpr_scale.sv
// Divides the PID sum by 1000 through a reciprocal multiply and selects the heater level.
module cpr_scale (
  input  cpr_pkg::heat_req_t         req_i,
  output logic [cpr_pkg::LEVEL_W-1:0] level_o
);
  import cpr_pkg::*;

  logic [DIV_W+RECIP_W-1:0] prod;

  assign prod    = (DIV_W+RECIP_W)'(req_i.num) * (DIV_W+RECIP_W)'(RECIP_K);
  assign level_o = req_i.scale ? prod[RECIP_SHIFT +: LEVEL_W] : req_i.level;

endmodule

FILE: rtl/climate_pid_relay_controller.sv
// Climate controller top level: heater PID, humidifier relay and exhaust fan relay.
//
// Each sensor request on the input channel (in_valid_i, in_stall_o) carries an
// action code with temperature and humidity, and yields exactly one request on
// the output channel (out_valid_o, out_stall_i) with the heater level and the
// relay states. A request is taken at a clock edge with valid high and stall low.
// The block is a three-register pipeline: input register, PID and relay stage
// register, output register. A request goes on through the stage register to the
// output register; one request is taken per cycle when the output is not stalled.
// The PID integral, previous error and relays update as a request leaves the
// input register, so each request sees the state left by the one before it.
// When the receiver stalls, the pipeline fills and in_stall_o rises once all
// three registers hold requests; nothing is dropped. Configuration registers are
// written through cfg_we_i, cfg_index_i and cfg_data_i; the user must write them
// only while the block is idle, which the block does not enforce. Reset clears
// the pipeline, the PID state and the relays, and loads default targets and gains.
module climate_pid_relay_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] current_temp_i,
  input  logic [15:0] current_humi_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  heat_output_o,
  output logic        heat_written_o,
  output logic        humidifier_on_o,
  output logic        humidifier_changed_o,
  output logic        fan_on_o,
  output logic        fan_changed_o
);
  import cpr_pkg::*;

  logic [15:0] target_temp_q, target_humi_q, gain_p_q, gain_i_q, gain_d_q;
  logic [2:0]  manual_modes_q;

  logic        s1_valid_q, s2_valid_q, out_valid_q;
  logic [1:0]  s1_action_q;
  logic [15:0] s1_temp_q, s1_humi_q;
  heat_req_t   s2_heat_q;
  relay_t      s2_relay_q;
  logic [9:0]  out_heat_q;
  logic        out_written_q;
  relay_t      out_relay_q;

  logic        adv_out, adv_s2, adv_s1, step;
  heat_req_t   heat_req;
  relay_t      relay;
  logic [9:0]  level;

  assign adv_out    = !out_valid_q || !out_stall_i;
  assign adv_s2     = !s2_valid_q || adv_out;
  assign adv_s1     = !s1_valid_q || adv_s2;
  assign step       = s1_valid_q && adv_s2;
  assign in_stall_o = !adv_s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_temp_q  <= 16'd3750;
      target_humi_q  <= 16'd6000;
      gain_p_q       <= 16'd2000;
      gain_i_q       <= 16'd15;
      gain_d_q       <= 16'd500;
      manual_modes_q <= 3'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TARGET_TEMP:  target_temp_q  <= cfg_data_i;
        CFG_TARGET_HUMI:  target_humi_q  <= cfg_data_i;
        CFG_GAIN_P:       gain_p_q       <= cfg_data_i;
        CFG_GAIN_I:       gain_i_q       <= cfg_data_i;
        CFG_GAIN_D:       gain_d_q       <= cfg_data_i;
        CFG_MANUAL_MODES: manual_modes_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv_s2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (adv_out) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s1 && in_valid_i) begin
      s1_action_q <= action_i;
      s1_temp_q   <= current_temp_i;
      s1_humi_q   <= current_humi_i;
    end
    if (step) begin
      s2_heat_q  <= heat_req;
      s2_relay_q <= relay;
    end
    if (adv_out && s2_valid_q) begin
      out_heat_q    <= level;
      out_written_q <= s2_heat_q.written;
      out_relay_q   <= s2_relay_q;
    end
  end

  cpr_pid u_pid (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .action_i      (s1_action_q),
    .cur_temp_i    (s1_temp_q),
    .target_temp_i (target_temp_q),
    .gain_p_i      (gain_p_q),
    .gain_i_i      (gain_i_q),
    .gain_d_i      (gain_d_q),
    .manual_heat_i (manual_modes_q[MODE_HEAT]),
    .heat_o        (heat_req)
  );

  cpr_relay u_relay (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .action_i      (s1_action_q),
    .cur_temp_i    (s1_temp_q),
    .cur_humi_i    (s1_humi_q),
    .target_temp_i (target_temp_q),
    .target_humi_i (target_humi_q),
    .manual_humi_i (manual_modes_q[MODE_HUMI]),
    .manual_fan_i  (manual_modes_q[MODE_FAN]),
    .relay_o       (relay)
  );

  cpr_scale u_scale (
    .req_i   (s2_heat_q),
    .level_o (level)
  );

  assign out_valid_o          = out_valid_q;
  assign heat_output_o        = out_heat_q;
  assign heat_written_o       = out_written_q;
  assign humidifier_on_o      = out_relay_q.humi_on;
  assign humidifier_changed_o = out_relay_q.humi_chg;
  assign fan_on_o             = out_relay_q.fan_on;
  assign fan_changed_o        = out_relay_q.fan_chg;

endmodule
